// ===== rtl/identifier_token_splitter_assert.svh =====
// assertion macros used by the checker file of the token splitter
`ifndef IDENTIFIER_TOKEN_SPLITTER_ASSERT_SVH
`define IDENTIFIER_TOKEN_SPLITTER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define ITS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("token splitter assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ITS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("token splitter assertion failed");

`endif

// ===== rtl/its_pkg.sv =====
// shared types, constants and character classes of the token splitter
`default_nettype none

package its_pkg;

	typedef logic [15:0] pos_t;

	// offsets saturate here
	localparam pos_t POS_CAP = 16'hFFFF;

	typedef enum logic [2:0] {
		MODE_NONE,
		MODE_ALPHA,
		MODE_NUMBER,
		MODE_COLON,
		MODE_OPER
	} mode_t;

	typedef logic [3:0] kw_t;
	localparam kw_t KW_LEN     = 4'd8;
	localparam kw_t MATCH_FAIL = 4'd15;

	// keyword written back to front so that index 0 holds its first letter
	localparam logic [7:0][7:0] KW_TEXT = "rotarepo";

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_LOW_O  = 8'h6F;

	typedef logic [1:0] tok_cnt_t;

	// all tokens caused by one input byte
	typedef struct packed {
		tok_cnt_t         count;
		logic [2:0][15:0] starts;
		logic [2:0][15:0] ends;
	} bundle_t;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	function automatic logic is_upper(input logic [7:0] c);
		return c inside {[8'h41:8'h5A]};
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return c inside {[8'h61:8'h7A]};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return (c == CH_DOLLAR) || (c == CH_UNDER) || is_lower(c) || is_upper(c);
	endfunction

	function automatic pos_t sat_inc(input pos_t v);
		return (v >= POS_CAP) ? POS_CAP : pos_t'(v + 16'd1);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/its_front.sv =====
// front end: scans one byte per transaction and forms the token bundle for it
`default_nettype none

module its_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic [7:0]     ch,
	input  wire logic           end_of_text,
	output its_pkg::bundle_t    bundle
);
	import its_pkg::*;

	mode_t mode_q, mode_n;
	pos_t  run_q, run_n;
	pos_t  part_q, part_n;
	pos_t  pos_q, nxt;
	logic  dollar_q, dollar_n;
	logic  skip_q, skip_n;
	kw_t   kw_q, kw_n;
	logic  sep;

	assign nxt = sat_inc(pos_q);
	assign sep = !is_word(ch) && !is_digit(ch);

	// next state
	always_comb begin
		mode_n   = mode_q;
		run_n    = run_q;
		part_n   = part_q;
		dollar_n = dollar_q;
		skip_n   = skip_q;
		kw_n     = kw_q;
		if (skip_q) begin
			skip_n = 1'b0;
		end else begin
			case (mode_q)
				MODE_NONE: begin
					run_n  = pos_q;
					part_n = pos_q;
					if (is_word(ch)) begin
						mode_n   = MODE_ALPHA;
						dollar_n = (ch == CH_DOLLAR);
						kw_n     = (ch == CH_LOW_O) ? kw_t'(1) : MATCH_FAIL;
					end else if (is_digit(ch)) begin
						mode_n   = MODE_NUMBER;
						dollar_n = 1'b0;
						kw_n     = MATCH_FAIL;
					end
				end
				MODE_ALPHA: begin
					if (sep) begin
						mode_n = (ch == CH_COLON) ? MODE_COLON : MODE_NONE;
						if (run_q == part_q && kw_q == KW_LEN) begin
							part_n = pos_q;
							mode_n = MODE_OPER;
						end
						run_n = pos_q;
					end else begin
						if (kw_q < KW_LEN && ch == KW_TEXT[kw_q[2:0]])
							kw_n = kw_t'(kw_q + 4'd1);
						else
							kw_n = MATCH_FAIL;
						if (is_upper(ch) || is_digit(ch)) begin
							part_n = pos_q;
						end else if (ch == CH_UNDER && !dollar_q) begin
							part_n = nxt;
							skip_n = 1'b1;
						end
					end
				end
				MODE_NUMBER: begin
					if (is_digit(ch)) begin
						mode_n = MODE_NUMBER;
					end else if (is_word(ch)) begin
						part_n = pos_q;
						mode_n = MODE_ALPHA;
						kw_n   = MATCH_FAIL;
					end else begin
						mode_n = (ch == CH_COLON) ? MODE_COLON : MODE_NONE;
						run_n  = pos_q;
					end
				end
				MODE_COLON: begin
					mode_n = MODE_NONE;
				end
				MODE_OPER: begin
					if (ch == CH_LPAREN)
						mode_n = MODE_NONE;
				end
				default: begin
					mode_n = MODE_NONE;
				end
			endcase
		end
	end

	// tokens of this byte, the end flush uses the updated run and part
	always_comb begin
		tok_cnt_t n;
		n = '0;
		bundle = '0;
		if (!skip_q) begin
			case (mode_q)
				MODE_ALPHA: begin
					if (sep) begin
						bundle.starts[n] = run_q;  bundle.ends[n] = pos_q; n = n + 2'd1;
						if (run_q != part_q) begin
							bundle.starts[n] = part_q; bundle.ends[n] = pos_q; n = n + 2'd1;
						end
					end else if (is_upper(ch) || is_digit(ch)
							|| (ch == CH_UNDER && !dollar_q)) begin
						bundle.starts[n] = part_q; bundle.ends[n] = pos_q; n = n + 2'd1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit(ch)) begin
						n = n;
					end else if (is_word(ch)) begin
						bundle.starts[n] = part_q; bundle.ends[n] = pos_q; n = n + 2'd1;
					end else begin
						bundle.starts[n] = run_q;  bundle.ends[n] = pos_q; n = n + 2'd1;
						if (run_q != part_q) begin
							bundle.starts[n] = part_q; bundle.ends[n] = pos_q; n = n + 2'd1;
						end
					end
				end
				MODE_COLON: begin
					if (ch == CH_COLON) begin
						bundle.starts[n] = run_q; bundle.ends[n] = nxt; n = n + 2'd1;
					end
				end
				MODE_OPER: begin
					if (ch == CH_LPAREN) begin
						bundle.starts[n] = run_q; bundle.ends[n] = pos_q; n = n + 2'd1;
					end
				end
				default: begin
					n = n;
				end
			endcase
		end
		if (end_of_text) begin
			if (mode_n == MODE_ALPHA || mode_n == MODE_NUMBER) begin
				bundle.starts[n] = run_n; bundle.ends[n] = nxt; n = n + 2'd1;
				if (run_n != part_n) begin
					bundle.starts[n] = part_n; bundle.ends[n] = nxt; n = n + 2'd1;
				end
			end else if (mode_n == MODE_OPER) begin
				bundle.starts[n] = run_n; bundle.ends[n] = nxt; n = n + 2'd1;
			end
		end
		bundle.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NONE;
			run_q    <= '0;
			part_q   <= '0;
			pos_q    <= '0;
			dollar_q <= 1'b0;
			skip_q   <= 1'b0;
			kw_q     <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				mode_q   <= MODE_NONE;
				run_q    <= '0;
				part_q   <= '0;
				pos_q    <= '0;
				dollar_q <= 1'b0;
				skip_q   <= 1'b0;
				kw_q     <= '0;
			end else begin
				mode_q   <= mode_n;
				run_q    <= run_n;
				part_q   <= part_n;
				pos_q    <= nxt;
				dollar_q <= dollar_n;
				skip_q   <= skip_n;
				kw_q     <= kw_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/its_fifo.sv =====
// short bundle queue between the front end and the token drain, with a registered read port
`default_nettype none

module its_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  its_pkg::bundle_t      wr_data,
	input  wire logic             rd_en,
	output its_pkg::bundle_t      rd_data,
	output logic                  full,
	output logic                  empty
);
	import its_pkg::*;

	bundle_t                mem_q [FIFO_DEPTH];
	bundle_t                rd_data_q;
	logic [FIFO_AW-1:0]     wr_ptr_q;
	logic [FIFO_AW-1:0]     rd_ptr_q;
	logic [FIFO_AW:0]       count_q;

	assign full    = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
		if (rd_en)
			rd_data_q <= mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/its_back.sv =====
// back end: hands the tokens of the head bundle out one per transaction
`default_nettype none

module its_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  its_pkg::bundle_t    fifo_data,
	input  wire logic           fifo_empty,
	output logic                fifo_rd,
	input  wire logic           pop,
	output logic                empty,
	output logic [15:0]         token_start,
	output logic [15:0]         token_end,
	output logic                last_token
);
	import its_pkg::*;

	tok_cnt_t idx_q;
	logic     valid_q;
	logic     at_last;
	logic     load;

	assign at_last = (idx_q == tok_cnt_t'(fifo_data.count - 2'd1));
	// refill when idle or when the last token of the bundle leaves
	assign load    = !valid_q || (pop && at_last);
	assign fifo_rd = load && !fifo_empty;

	assign empty       = !valid_q;
	assign token_start = fifo_data.starts[idx_q];
	assign token_end   = fifo_data.ends[idx_q];
	assign last_token  = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !fifo_empty;
			idx_q   <= '0;
		end else if (pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/identifier_token_splitter.sv =====
// top level of the identifier token splitter
`default_nettype none

// Takes one byte of symbol text per cycle (push while full is low) and
// returns start/end offsets of the tokens found, one token per pop. Every
// byte is scanned in the cycle it is taken; a byte may cause up to three
// tokens, which travel together through a four-entry queue and are then
// handed out by the output stage one per cycle while pop is high. With the
// queue idle, the first token of a byte passes the queue memory and its read
// register on its way to the result ports. Input keeps flowing at one byte
// per cycle as long as tokens are popped on average as fast as they are made;
// full rises once four byte-bundles wait. last_token marks a byte's final token.
// end_of_text flushes pending tokens and returns the scanner to its start state.

module identifier_token_splitter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  ch,
	input  wire logic        end_of_text,
	output logic             empty,
	input  wire logic        pop,
	output logic [15:0]      token_start,
	output logic [15:0]      token_end,
	output logic             last_token
);
	import its_pkg::*;

	logic    accept;
	bundle_t front_bundle;
	bundle_t head_bundle;
	logic    fifo_wr;
	logic    fifo_rd;
	logic    fifo_empty;

	assign accept  = push && !full;
	// bytes that cause no token leave nothing in the queue
	assign fifo_wr = accept && (front_bundle.count != '0);

	its_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.ch          (ch),
		.end_of_text (end_of_text),
		.bundle      (front_bundle)
	);

	its_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fifo_wr),
		.wr_data (front_bundle),
		.rd_en   (fifo_rd),
		.rd_data (head_bundle),
		.full    (full),
		.empty   (fifo_empty)
	);

	its_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_data   (head_bundle),
		.fifo_empty  (fifo_empty),
		.fifo_rd     (fifo_rd),
		.pop         (pop),
		.empty       (empty),
		.token_start (token_start),
		.token_end   (token_end),
		.last_token  (last_token)
	);

endmodule

`default_nettype wire

// ===== rtl/its_checker.sv =====
// port-level checks of the token splitter and their bind
`default_nettype none

`include "identifier_token_splitter_assert.svh"

module its_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic        full,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic [15:0] token_start,
	input  wire logic [15:0] token_end,
	input  wire logic        last_token
);

	logic [32:0] result_w;

	assign result_w = {token_start, token_end, last_token};

	// a waiting token stays put until it is taken
	`ITS_ASSERT_NEXT(a_result_hold, clk, arst_n, !empty && !pop, !empty && $stable(result_w))

	// a token never ends before it starts
	`ITS_ASSERT_NOW(a_order, clk, arst_n, !empty, token_start <= token_end)

	// a full queue means tokens are waiting at the output
	`ITS_ASSERT_NOW(a_full_not_empty, clk, arst_n, full, !empty)

	// output leaves empty only after an accepted byte has passed the queue memory and its read register
	`ITS_ASSERT_NOW(a_fill_latency, clk, arst_n, $fell(empty), $past(push && !full, 2))

endmodule

bind identifier_token_splitter its_checker u_its_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_identifier_token_splitter.sv =====
// testbench of the identifier token splitter: directed table and random symbols
`timescale 1ns / 100ps

module tb_identifier_token_splitter;

	typedef enum logic [2:0] {
		SM_IDLE,
		SM_WORD,
		SM_DIGITS,
		SM_COLON,
		SM_OPNAME
	} scan_mode_t;

	typedef struct packed {
		scan_mode_t  mode;
		logic [15:0] run_start;
		logic [15:0] part_start;
		logic [15:0] pos;
		logic        dollar_lead;
		logic        skip_next;
		logic [3:0]  kw;
	} scan_t;

	typedef struct packed {
		logic [15:0] start_ofs;
		logic [15:0] end_ofs;
		logic        last;
	} token_t;

	typedef struct packed {
		logic [7:0]       c;
		logic             eot;
		logic             typed;
		logic [1:0]       n;
		token_t [2:0]     t;
	} stim_row_t;

	localparam logic [15:0] POS_LIMIT = 16'hFFFF;
	localparam logic [3:0]  KW_FULL   = 4'd8;
	localparam logic [3:0]  KW_MISS   = 4'd15;
	localparam logic [63:0] KW_WORD   = "operator";
	localparam logic [7:0]  DOLLAR_C  = "$";
	localparam logic [7:0]  UNDER_C   = "_";
	localparam logic [7:0]  COLON_C   = ":";
	localparam logic [7:0]  LPAREN_C  = "(";
	localparam logic [7:0]  SPACE_C   = " ";
	localparam int          N_RANDOM  = 185;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  ch = 8'h00;
	logic        end_of_text = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] token_start;
	logic [15:0] token_end;
	logic        last_token;

	scan_t     scan = '0;
	token_t    made [3];
	int        made_n;
	token_t    tokens_due [$];
	stim_row_t directed_rows [$];
	stim_row_t pending [$];
	stim_row_t live_row = '0;
	bit        tx_idle = 1'b1;
	bit        rx_idle = 1'b1;
	int        n_err = 0;
	int        n_bytes = 0;
	int        n_texts = 0;
	int        n_tokens = 0;

	identifier_token_splitter i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.ch          (ch),
		.end_of_text (end_of_text),
		.empty       (empty),
		.pop         (pop),
		.token_start (token_start),
		.token_end   (token_end),
		.last_token  (last_token)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit upper_char(input logic [7:0] c);
		return c >= "A" && c <= "Z";
	endfunction

	function automatic bit digit_char(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit ident_char(input logic [7:0] c);
		return c == DOLLAR_C || c == UNDER_C || upper_char(c) || (c >= "a" && c <= "z");
	endfunction

	function automatic void emit(input logic [15:0] s, input logic [15:0] e);
		if (made_n < 3) begin
			made[made_n] = '{s, e, 1'b0};
			made_n++;
		end
	endfunction

	// advances the scanner by one byte and leaves the tokens it causes in made
	function automatic void scan_byte(input logic [7:0] c, input logic eot);
		logic [15:0] i;
		logic [15:0] nxt;
		i = scan.pos;
		nxt = (i >= POS_LIMIT) ? POS_LIMIT : i + 16'd1;
		made_n = 0;
		if (scan.skip_next) begin
			scan.skip_next = 1'b0;
		end else begin
			case (scan.mode)
				SM_IDLE: begin
					scan.run_start = i;
					scan.part_start = i;
					if (ident_char(c)) begin
						scan.mode = SM_WORD;
						scan.dollar_lead = (c == DOLLAR_C);
						scan.kw = (c == KW_WORD[63 -: 8]) ? 4'd1 : KW_MISS;
					end else if (digit_char(c)) begin
						scan.mode = SM_DIGITS;
						scan.dollar_lead = 1'b0;
						scan.kw = KW_MISS;
					end
				end
				SM_WORD: begin
					if (!ident_char(c) && !digit_char(c)) begin
						scan.mode = (c == COLON_C) ? SM_COLON : SM_IDLE;
						emit(scan.run_start, i);
						if (scan.run_start != scan.part_start) begin
							emit(scan.part_start, i);
						end else if (scan.kw == KW_FULL) begin
							scan.part_start = i;
							scan.mode = SM_OPNAME;
						end
						scan.run_start = i;
					end else begin
						if (scan.kw < KW_FULL && c == KW_WORD[63 - 8 * scan.kw[2:0] -: 8])
							scan.kw = scan.kw + 4'd1;
						else
							scan.kw = KW_MISS;
						if (upper_char(c) || digit_char(c)) begin
							emit(scan.part_start, i);
							scan.part_start = i;
						end else if (c == UNDER_C && !scan.dollar_lead) begin
							emit(scan.part_start, i);
							scan.part_start = nxt;
							scan.skip_next = 1'b1;
						end
					end
				end
				SM_DIGITS: begin
					if (digit_char(c)) begin
					end else if (ident_char(c)) begin
						emit(scan.part_start, i);
						scan.part_start = i;
						scan.mode = SM_WORD;
						scan.kw = KW_MISS;
					end else begin
						emit(scan.run_start, i);
						if (scan.run_start != scan.part_start)
							emit(scan.part_start, i);
						scan.mode = (c == COLON_C) ? SM_COLON : SM_IDLE;
						scan.run_start = i;
					end
				end
				SM_COLON: begin
					if (c == COLON_C)
						emit(scan.run_start, nxt);
					scan.mode = SM_IDLE;
				end
				SM_OPNAME: begin
					if (c == LPAREN_C) begin
						emit(scan.run_start, i);
						scan.mode = SM_IDLE;
					end
				end
				default: scan.mode = SM_IDLE;
			endcase
		end
		scan.pos = nxt;
		if (eot) begin
			// flush whatever run is still open, then back to the start state
			if (scan.mode == SM_WORD || scan.mode == SM_DIGITS) begin
				emit(scan.run_start, nxt);
				if (scan.run_start != scan.part_start)
					emit(scan.part_start, nxt);
			end else if (scan.mode == SM_OPNAME) begin
				emit(scan.run_start, nxt);
			end
			scan = '0;
		end
		if (made_n > 0)
			made[made_n - 1].last = 1'b1;
	endfunction

	function automatic token_t tk(input int s, input int e, input bit l);
		return '{s[15:0], e[15:0], l};
	endfunction

	function automatic stim_row_t byte_row(input logic [7:0] c, input logic eot);
		stim_row_t r;
		r = '0;
		r.c = c;
		r.eot = eot;
		return r;
	endfunction

	function automatic stim_row_t typed_row(input logic [7:0] c, input logic eot, input int n,
			input token_t t0 = '0, input token_t t1 = '0, input token_t t2 = '0);
		stim_row_t r;
		r = byte_row(c, eot);
		r.typed = 1'b1;
		r.n = n[1:0];
		r.t[0] = t0;
		r.t[1] = t1;
		r.t[2] = t2;
		return r;
	endfunction

	task automatic send_byte(input stim_row_t r);
		int gap;
		gap = tx_idle ? $urandom_range(0, 8) : 0;
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		ch <= r.c;
		end_of_text <= r.eot;
		live_row = r;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic add_chars(input string s);
		for (int k = 0; k < s.len(); k++)
			pending.push_back(byte_row(s[k], 1'b0));
	endtask

	// one random symbol: mostly well-formed identifiers, some operator names, some noise
	task automatic make_text();
		int kind;
		int len;
		string ops;
		ops = "+-*=<>[]!~,";
		kind = $urandom_range(0, 9);
		if (kind >= 8) begin
			// noise, end flag anywhere or nowhere
			len = $urandom_range(1, 6);
			repeat (len)
				pending.push_back(byte_row(8'($urandom_range(0, 255)),
					$urandom_range(0, 2) == 0));
			return;
		end
		if (kind == 7) begin
			add_chars("operator");
			repeat ($urandom_range(1, 2))
				pending.push_back(byte_row(ops[$urandom_range(0, ops.len() - 1)], 1'b0));
			if ($urandom_range(0, 2) != 0) begin
				pending.push_back(byte_row(LPAREN_C, 1'b0));
				if ($urandom_range(0, 1) == 1)
					add_chars("int)");
			end
		end else begin
			if ($urandom_range(0, 5) == 0)
				pending.push_back(byte_row(DOLLAR_C, 1'b0));
			repeat ($urandom_range(1, 4)) begin
				case ($urandom_range(0, 6))
					0: repeat ($urandom_range(1, 4))
						pending.push_back(byte_row(8'($urandom_range("a", "z")), 1'b0));
					1: begin
						pending.push_back(byte_row(8'($urandom_range("A", "Z")), 1'b0));
						repeat ($urandom_range(0, 3))
							pending.push_back(byte_row(8'($urandom_range("a", "z")), 1'b0));
					end
					2: repeat ($urandom_range(1, 3))
						pending.push_back(byte_row(8'($urandom_range("0", "9")), 1'b0));
					3: pending.push_back(byte_row(UNDER_C, 1'b0));
					4: repeat ($urandom_range(1, 2))
						pending.push_back(byte_row(COLON_C, 1'b0));
					5: begin
						// prefixes of the keyword, sometimes followed by one more letter
						len = $urandom_range(1, 8);
						for (int k = 0; k < len; k++)
							pending.push_back(byte_row(KW_WORD[63 - 8 * k -: 8], 1'b0));
						if ($urandom_range(0, 2) == 0)
							pending.push_back(byte_row("s", 1'b0));
					end
					default: pending.push_back(byte_row(SPACE_C, 1'b0));
				endcase
			end
		end
		pending[pending.size() - 1].eot = 1'b1;
	endtask

	// scoreboard: compare popped tokens, predict on every accepted byte
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				n_tokens++;
				if (tokens_due.size() == 0) begin
					$error("token with nothing expected: start %0d end %0d", token_start, token_end);
					n_err++;
				end else begin
					if (token_start !== tokens_due[0].start_ofs) begin
						$error("token_start: expected %0d, got %0d",
							tokens_due[0].start_ofs, token_start);
						n_err++;
					end
					if (token_end !== tokens_due[0].end_ofs) begin
						$error("token_end: expected %0d, got %0d", tokens_due[0].end_ofs, token_end);
						n_err++;
					end
					if (last_token !== tokens_due[0].last) begin
						$error("last_token: expected %0d, got %0d", tokens_due[0].last, last_token);
						n_err++;
					end
					void'(tokens_due.pop_front());
				end
			end
			if (push && !full) begin
				n_bytes++;
				if (end_of_text)
					n_texts++;
				scan_byte(ch, end_of_text);
				if (live_row.typed) begin
					for (int k = 0; k < live_row.n; k++)
						tokens_due.push_back(live_row.t[k]);
				end else begin
					for (int k = 0; k < made_n; k++)
						tokens_due.push_back(made[k]);
				end
			end
		end
	end

	// result side: random pop stalls per transaction
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = rx_idle ? $urandom_range(0, 8) : 0;
			repeat (gap) begin
				@(negedge clk);
				pop <= 1'b0;
			end
			@(negedge clk);
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int n_rand;
		n_rand = 0;

		// single letter, bytes at both ends of the range
		directed_rows.push_back(typed_row("a", 1'b1, 1, tk(0, 1, 1)));
		directed_rows.push_back(typed_row(8'hFF, 1'b1, 0));
		directed_rows.push_back(typed_row(8'h00, 1'b1, 0));
		// underscore on the final byte leaves an empty part
		directed_rows.push_back(typed_row("a", 1'b0, 0));
		directed_rows.push_back(typed_row(UNDER_C, 1'b1, 3, tk(0, 1, 0), tk(0, 2, 0), tk(2, 2, 1)));
		// digits into letters, capital split, underscore split with the end on the skipped byte
		directed_rows.push_back(byte_row("7", 1'b0));
		directed_rows.push_back(byte_row("x", 1'b0));
		directed_rows.push_back(byte_row("Y", 1'b0));
		directed_rows.push_back(byte_row(UNDER_C, 1'b0));
		directed_rows.push_back(byte_row("z", 1'b1));
		// scope pair
		directed_rows.push_back(typed_row("a", 1'b0, 0));
		directed_rows.push_back(typed_row(COLON_C, 1'b0, 1, tk(0, 1, 1)));
		directed_rows.push_back(typed_row(COLON_C, 1'b0, 1, tk(1, 3, 1)));
		directed_rows.push_back(typed_row("b", 1'b1, 1, tk(3, 4, 1)));
		// operator name up to the open paren
		for (int k = 0; k < 8; k++)
			directed_rows.push_back(byte_row(KW_WORD[63 - 8 * k -: 8], 1'b0));
		directed_rows.push_back(typed_row("*", 1'b0, 1, tk(0, 8, 1)));
		directed_rows.push_back(typed_row(LPAREN_C, 1'b1, 1, tk(8, 9, 1)));

		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k])
			send_byte(directed_rows[k]);

		while (n_rand < N_RANDOM) begin
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			make_text();
			while (pending.size() != 0) begin
				send_byte(pending.pop_front());
				n_rand++;
			end
		end

		tx_idle = 1'b0;
		rx_idle = 1'b0;
		@(negedge clk);
		push <= 1'b0;

		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);

		$display("covered %0d bytes in %0d flagged texts, %0d tokens compared", n_bytes, n_texts,
			n_tokens);
		$display("directed table, then random symbols with noise bytes and stray end flags");
		if (n_err == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
